// ===== design/frame_rate_and_stage_cost_monitor_defines.svh =====
// Assertion macros shared by the monitor's RTL files.
// No dependencies.
`ifndef FRAME_RATE_AND_STAGE_COST_MONITOR_DEFINES_SVH
`define FRAME_RATE_AND_STAGE_COST_MONITOR_DEFINES_SVH

// Property checked on every rising clock edge, disabled while reset is held.
`define FRSC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// The same check, also evaluated while reset is held.
`define FRSC_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== design/frsc_pkg.sv =====
// Package for the frame rate and stage cost monitor: sizes, op codes and the state type.
// No dependencies.
`default_nettype none
package frsc_pkg;
    localparam int FRAME_WINDOW_DEF  = 500;
    localparam int SAMPLE_WINDOW_DEF = 20;
    localparam int NUM_KINDS_DEF     = 16;

    localparam int TIME_W  = 48;
    localparam int COST_W  = 32;
    localparam int KIND_W  = 4;
    localparam int OP_W    = 2;
    localparam int QUOT_W  = 64;
    // 1e6 us per second, scaled by 256 for Q24.8
    localparam logic [63:0] US_PER_S_Q8 = 64'd256000000;

    typedef enum logic [OP_W-1:0] {
        OP_MARK  = 2'd0,
        OP_DONE  = 2'd1,
        OP_FRAME = 2'd2,
        OP_QUERY = 2'd3
    } op_t;

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_RD     = 8'b0000_0010,
        ST_UPD    = 8'b0000_0100,
        ST_FRD    = 8'b0000_1000,
        ST_FSET   = 8'b0001_0000,
        ST_DIV    = 8'b0010_0000,
        ST_FIN    = 8'b0100_0000,
        ST_OUT    = 8'b1000_0000
    } state_t;

    // start and status between sequencer and the serial divider
    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } div_ctl_t;
endpackage
`default_nettype wire

// ===== design/frame_rate_and_stage_cost_monitor.sv =====
// Top level of the frame rate and stage cost monitor: sequencer, state and RAMs.
// Depends on frsc_pkg, frsc_ram, frsc_div and the shared assertion macros.
//
// channel | dir | fields (low bit first)
// s_axis  | in  | tdata: op[1:0] kind[5:2] time_us[53:6]
// m_axis  | out | tdata: avg_cost_us[31:0] sample_count[36:32] frame_rate_q8[68:37]
//         |     |        frame_count[77:69]
// cfg     | in  | data: frame_kind[3:0]
//
// The result is valid after the sequencer steps through ST_RD and ST_UPD for RAM reads
// and updates, ST_FRD and ST_FSET, then ST_DIV while the bit-serial divider produces both
// quotients, until its done flag, then ST_FIN and ST_OUT to register and present the
// result. Reset clears all counters
// and sums; RAM contents stay undefined until written. A stalled result holds the
// block; the next item is taken the cycle after the result is consumed.
`include "frame_rate_and_stage_cost_monitor_defines.svh"
`default_nettype none
module frame_rate_and_stage_cost_monitor #(
    parameter int FRAME_WINDOW  = frsc_pkg::FRAME_WINDOW_DEF,
    parameter int SAMPLE_WINDOW = frsc_pkg::SAMPLE_WINDOW_DEF,
    parameter int NUM_KINDS     = frsc_pkg::NUM_KINDS_DEF
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire [55:0]  s_axis_tdata,   // op, kind, time_us
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [79:0] m_axis_tdata,   // avg_cost_us, sample_count, frame_rate_q8, frame_count
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire [7:0]   cfg_data        // frame_kind
);
    localparam int TW  = frsc_pkg::TIME_W;
    localparam int CW  = frsc_pkg::COST_W;
    localparam int QW  = frsc_pkg::QUOT_W;
    localparam int FAW = (FRAME_WINDOW > 1) ? $clog2(FRAME_WINDOW) : 1;
    localparam int FCW = $clog2(FRAME_WINDOW + 1);
    localparam int SCW = $clog2(SAMPLE_WINDOW + 1);
    localparam int SHW = (SAMPLE_WINDOW > 1) ? $clog2(SAMPLE_WINDOW) : 1;
    localparam int KW  = (NUM_KINDS > 1) ? $clog2(NUM_KINDS) : 1;
    localparam int CDEPTH = NUM_KINDS * SAMPLE_WINDOW;
    localparam int CAW = $clog2(CDEPTH + 1);
    localparam int SUMW = CW + SCW;

    frsc_pkg::state_t state_reg;
    logic [frsc_pkg::KIND_W-1:0] fkind_reg;
    logic [frsc_pkg::OP_W-1:0]   op_reg;
    logic [frsc_pkg::KIND_W-1:0] kind_reg;
    logic [TW-1:0]  time_reg, last_reg, newest_reg;
    logic [FAW-1:0] fhead_reg;
    logic [FCW-1:0] fheld_reg;
    logic [SHW-1:0] chead_reg [NUM_KINDS];
    logic [SCW-1:0] cheld_reg [NUM_KINDS];
    logic [SUMW-1:0] csum_reg [NUM_KINDS];
    logic [CW-1:0]  avg_reg, rate_reg;
    logic [SCW-1:0] cnt_reg;
    logic [FCW-1:0] fcnt_reg;
    logic           outv_reg;
    logic           rate_sat_reg, rate_zero_reg, kvalid_reg;
    logic [KW-1:0]  rk_reg;
    logic [TW-1:0]  span_reg;

    // decoded input fields
    logic [frsc_pkg::OP_W-1:0]   in_op;
    logic [frsc_pkg::KIND_W-1:0] in_kind;
    logic [TW-1:0]               in_time;
    assign in_op   = s_axis_tdata[1:0];
    assign in_kind = s_axis_tdata[5:2];
    assign in_time = s_axis_tdata[53:6];

    logic [frsc_pkg::KIND_W-1:0] rep_kind;
    assign rep_kind = (op_reg == frsc_pkg::OP_FRAME) ? fkind_reg : kind_reg;
    logic rep_ok;
    assign rep_ok = 32'(rep_kind) < 32'(NUM_KINDS);
    logic [KW-1:0] rk;
    assign rk = KW'(rep_kind);
    logic records;
    assign records = (op_reg == frsc_pkg::OP_DONE) || (op_reg == frsc_pkg::OP_FRAME);

    // cost of this event, saturated and floored at zero
    logic [TW-1:0] elapsed;
    logic [CW-1:0] cost;
    assign elapsed = (time_reg >= last_reg) ? time_reg - last_reg : '0;
    assign cost = (elapsed[TW-1:CW] != '0) ? '1 : elapsed[CW-1:0];

    // cost RAM
    logic [CAW-1:0] cslot;
    logic [CW-1:0]  cold;
    logic           cwe;
    assign cslot = CAW'(32'(rk) * SAMPLE_WINDOW + 32'(chead_reg[rk]));
    assign cwe = (state_reg == frsc_pkg::ST_UPD) && records && rep_ok;
    frsc_ram #(.WIDTH(CW), .DEPTH(CDEPTH)) u_cost_ram (
        .clk(clk), .we(cwe), .waddr(cslot[$clog2(CDEPTH)-1:0]), .wdata(cost),
        .raddr(cslot[$clog2(CDEPTH)-1:0]), .rdata(cold)
    );

    // frame RAM: write in the ST_RD step, read oldest afterwards
    logic           fwe;
    logic [FAW-1:0] fold_addr;
    logic [TW-1:0]  fold;
    logic [FAW:0]   fsum;
    assign fwe = (state_reg == frsc_pkg::ST_RD) && (op_reg == frsc_pkg::OP_FRAME);
    assign fsum = {1'b0, fhead_reg} + (FAW+1)'(FRAME_WINDOW) - (FAW+1)'(fheld_reg);
    assign fold_addr = (fsum >= (FAW+1)'(FRAME_WINDOW)) ?
                       FAW'(fsum - (FAW+1)'(FRAME_WINDOW)) : FAW'(fsum);
    frsc_ram #(.WIDTH(TW), .DEPTH(FRAME_WINDOW)) u_frame_ram (
        .clk(clk), .we(fwe), .waddr(fhead_reg), .wdata(time_reg),
        .raddr(fold_addr), .rdata(fold)
    );

    // divider
    frsc_pkg::div_ctl_t dctl;
    logic [QW-1:0] qa, qb, num_b;
    logic          dstart;
    assign dstart = (state_reg == frsc_pkg::ST_FSET);
    assign num_b  = QW'(fheld_reg) * frsc_pkg::US_PER_S_Q8;
    frsc_div u_div (
        .clk(clk), .rst_n(rst_n), .start(dstart),
        .num_a(QW'(csum_reg[rk_reg])),
        .den_a((cnt_reg == '0) ? QW'(1) : QW'(cnt_reg)),
        .num_b(num_b),
        .den_b((span_reg == '0) ? QW'(1) : QW'(span_reg)),
        .ctl(dctl), .quo_a(qa), .quo_b(qb)
    );

    assign s_axis_tready = (state_reg == frsc_pkg::ST_IDLE) && !outv_reg;
    assign cfg_ready = 1'b1;
    assign m_axis_tvalid = outv_reg;
    assign m_axis_tdata = {2'b0, 9'(fcnt_reg), rate_reg, 5'(cnt_reg), avg_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= frsc_pkg::ST_IDLE;
            fkind_reg  <= '0;
            last_reg   <= '0;
            newest_reg <= '0;
            fhead_reg  <= '0;
            fheld_reg  <= '0;
            outv_reg   <= 1'b0;
            rk_reg     <= '0;
            kvalid_reg <= 1'b0;
            cnt_reg    <= '0;
            for (int i = 0; i < NUM_KINDS; i++)
            begin
                chead_reg[i] <= '0;
                cheld_reg[i] <= '0;
                csum_reg[i]  <= '0;
            end
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                fkind_reg <= cfg_data[3:0];
            end
            if (outv_reg && m_axis_tready)
            begin
                outv_reg <= 1'b0;
            end
            unique case (state_reg)
                frsc_pkg::ST_IDLE:
                begin
                    if (s_axis_tvalid && s_axis_tready)
                    begin
                        state_reg <= frsc_pkg::ST_RD;
                    end
                end
                frsc_pkg::ST_RD:
                begin
                    // frame push, cost RAM read in flight
                    if (op_reg == frsc_pkg::OP_FRAME)
                    begin
                        newest_reg <= time_reg;
                        fhead_reg <= (32'(fhead_reg) == FRAME_WINDOW - 1) ? '0 : fhead_reg + 1'b1;
                        if (32'(fheld_reg) < FRAME_WINDOW)
                        begin
                            fheld_reg <= fheld_reg + 1'b1;
                        end
                    end
                    state_reg <= frsc_pkg::ST_UPD;
                end
                frsc_pkg::ST_UPD:
                begin
                    if (op_reg != frsc_pkg::OP_QUERY)
                    begin
                        last_reg <= time_reg;
                    end
                    if (records && rep_ok)
                    begin
                        if (32'(cheld_reg[rk]) >= SAMPLE_WINDOW)
                        begin
                            csum_reg[rk] <= csum_reg[rk] - SUMW'(cold) + SUMW'(cost);
                        end
                        else
                        begin
                            cheld_reg[rk] <= cheld_reg[rk] + 1'b1;
                            csum_reg[rk]  <= csum_reg[rk] + SUMW'(cost);
                        end
                        chead_reg[rk] <= (32'(chead_reg[rk]) == SAMPLE_WINDOW - 1) ?
                                         '0 : chead_reg[rk] + 1'b1;
                    end
                    state_reg <= frsc_pkg::ST_FRD;
                end
                frsc_pkg::ST_FRD:
                begin
                    // oldest frame read data available
                    rk_reg <= rk;
                    kvalid_reg <= rep_ok;
                    state_reg <= frsc_pkg::ST_FSET;
                    cnt_reg <= rep_ok ? cheld_reg[rk] : '0;
                end
                frsc_pkg::ST_FSET:
                begin
                    state_reg <= frsc_pkg::ST_DIV;
                end
                frsc_pkg::ST_DIV:
                begin
                    if (dctl.done)
                    begin
                        state_reg <= frsc_pkg::ST_FIN;
                    end
                end
                frsc_pkg::ST_FIN:
                begin
                    state_reg <= frsc_pkg::ST_OUT;
                end
                frsc_pkg::ST_OUT:
                begin
                    outv_reg  <= 1'b1;
                    state_reg <= frsc_pkg::ST_IDLE;
                end
                default:
                begin
                    state_reg <= frsc_pkg::ST_IDLE;
                end
            endcase
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            op_reg   <= in_op;
            kind_reg <= in_kind;
            time_reg <= in_time;
        end
        if (state_reg == frsc_pkg::ST_FRD)
        begin
            span_reg      <= (fheld_reg >= FCW'(2) && newest_reg > fold) ? newest_reg - fold : '0;
            rate_zero_reg <= fheld_reg < FCW'(2);
            rate_sat_reg  <= fheld_reg >= FCW'(2) && newest_reg <= fold;
            fcnt_reg      <= fheld_reg;
        end
        if (state_reg == frsc_pkg::ST_FIN)
        begin
            avg_reg  <= (kvalid_reg && cnt_reg != '0) ? qa[CW-1:0] : '0;
            rate_reg <= rate_zero_reg ? '0 :
                        (rate_sat_reg || qb[QW-1:CW] != '0) ? '1 : qb[CW-1:0];
        end
    end

    `FRSC_ASSERT_ALWAYS(a_rst_idle, !rst_n |-> !m_axis_tvalid, "output valid in reset")
    `FRSC_ASSERT(a_no_take_busy, s_axis_tready |-> state_reg == frsc_pkg::ST_IDLE,
        "input taken while busy")
    `FRSC_ASSERT(a_fheld_max, 32'(fheld_reg) <= FRAME_WINDOW, "frame count over window")
    `FRSC_ASSERT(a_out_after_div, $rose(m_axis_tvalid) |-> $past(state_reg == frsc_pkg::ST_OUT),
        "result without division")
endmodule
`default_nettype wire

// ===== design/frsc_ram.sv =====
// Generic single-port-write, one-read RAM with registered read data.
// No dependencies.
`default_nettype none
module frsc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire                      clk,
    input  wire                      we,
    input  wire [$clog2(DEPTH)-1:0]  waddr,
    input  wire [WIDTH-1:0]          wdata,
    input  wire [$clog2(DEPTH)-1:0]  raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ===== design/frsc_div.sv =====
// Restoring bit-serial divider, one quotient bit per cycle, two lanes run together.
// Depends on frsc_pkg and the shared assertion macros.
`include "frame_rate_and_stage_cost_monitor_defines.svh"
`default_nettype none
module frsc_div (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          start,
    // lane A: cost sum / count
    input  wire [frsc_pkg::QUOT_W-1:0]   num_a,
    input  wire [frsc_pkg::QUOT_W-1:0]   den_a,
    // lane B: frames * 256e6 / span
    input  wire [frsc_pkg::QUOT_W-1:0]   num_b,
    input  wire [frsc_pkg::QUOT_W-1:0]   den_b,
    output frsc_pkg::div_ctl_t           ctl,
    output logic [frsc_pkg::QUOT_W-1:0]  quo_a,
    output logic [frsc_pkg::QUOT_W-1:0]  quo_b
);
    localparam int W  = frsc_pkg::QUOT_W;
    localparam int CW = $clog2(W + 1);

    logic [CW-1:0]  cnt_reg;
    logic           busy_reg, done_reg;
    logic [W-1:0]   qa_reg, qb_reg, ra_reg, rb_reg, da_reg, db_reg;
    logic [W:0]     ta, tb;

    assign ta = {ra_reg, qa_reg[W-1]};
    assign tb = {rb_reg, qb_reg[W-1]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            qa_reg <= num_a;
            qb_reg <= num_b;
            ra_reg <= '0;
            rb_reg <= '0;
            da_reg <= den_a;
            db_reg <= den_b;
        end
        else if (busy_reg)
        begin
            if (ta >= {1'b0, da_reg})
            begin
                ra_reg <= W'(ta - {1'b0, da_reg});
                qa_reg <= {qa_reg[W-2:0], 1'b1};
            end
            else
            begin
                ra_reg <= ta[W-1:0];
                qa_reg <= {qa_reg[W-2:0], 1'b0};
            end
            if (tb >= {1'b0, db_reg})
            begin
                rb_reg <= W'(tb - {1'b0, db_reg});
                qb_reg <= {qb_reg[W-2:0], 1'b1};
            end
            else
            begin
                rb_reg <= tb[W-1:0];
                qb_reg <= {qb_reg[W-2:0], 1'b0};
            end
        end
    end

    assign ctl.start = start;
    assign ctl.busy  = busy_reg;
    assign ctl.done  = done_reg;
    assign quo_a = qa_reg;
    assign quo_b = qb_reg;

    `FRSC_ASSERT(a_no_restart, start |-> !busy_reg, "divider started while busy")
    `FRSC_ASSERT(a_done_end, done_reg |-> $past(busy_reg), "done without a run")
    `FRSC_ASSERT(a_cnt_idle, !busy_reg |-> cnt_reg == '0, "count left over")
endmodule
`default_nettype wire

// ===== test/frame_rate_and_stage_cost_monitor_tb.sv =====
// Self-checking testbench for frame_rate_and_stage_cost_monitor.
// Drives timestamped events, predicts cost averages and frame rate in place.
// Depends on frsc_pkg and the monitor RTL.
`default_nettype none
module frame_rate_and_stage_cost_monitor_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FW = 500;
    localparam int SW = 20;
    localparam int NK = 16;

    typedef struct packed {
        logic [47:0]     time_us;
        logic [3:0]      kind;
        frsc_pkg::op_t   op;
    } event_t;

    typedef struct packed {
        logic [8:0]  frame_count;
        logic [31:0] frame_rate_q8;
        logic [4:0]  sample_count;
        logic [31:0] avg_cost_us;
    } report_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [55:0] s_axis_tdata = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [79:0] m_axis_tdata;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [7:0] cfg_data = '0;

    frame_rate_and_stage_cost_monitor i_dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // shadow state of the monitor
    logic [47:0] frame_ring [FW];
    int          frame_wr;
    int          frame_fill;
    logic [47:0] mark_time;
    logic [31:0] cost_ring [NK][SW];
    int          cost_wr [NK];
    int          cost_fill [NK];
    logic [36:0] cost_total [NK];
    logic [3:0]  frame_kind;

    event_t  pending_events [$];
    report_t expected_reports [$];
    int      errors = 0;
    int      send_idle_pct = 0;
    int      recv_idle_pct = 0;
    logic [47:0] clock_us = 48'd100;
    logic    s_axis_tready_q = 1'b0;

    function automatic void add_cost(input logic [3:0] k, input logic [47:0] now);
        logic [47:0] dt;
        logic [31:0] c;
        dt = (now >= mark_time) ? now - mark_time : 48'd0;
        c = (dt > 48'hFFFF_FFFF) ? 32'hFFFF_FFFF : dt[31:0];
        mark_time = now;
        if (cost_fill[k] >= SW)
            cost_total[k] -= 37'(cost_ring[k][cost_wr[k]]);
        else
            cost_fill[k]++;
        cost_ring[k][cost_wr[k]] = c;
        cost_total[k] += 37'(c);
        cost_wr[k] = (cost_wr[k] + 1) % SW;
    endfunction

    function automatic report_t predict_report(input event_t ev);
        report_t r;
        logic [3:0] k;
        logic [47:0] tn, t0;
        logic [63:0] q;
        k = ev.kind;
        case (ev.op)
            frsc_pkg::OP_MARK: mark_time = ev.time_us;
            frsc_pkg::OP_DONE: add_cost(ev.kind, ev.time_us);
            frsc_pkg::OP_FRAME:
            begin
                frame_ring[frame_wr] = ev.time_us;
                frame_wr = (frame_wr + 1) % FW;
                if (frame_fill < FW)
                    frame_fill++;
                add_cost(frame_kind, ev.time_us);
                k = frame_kind;
            end
            default: ;
        endcase
        r = '0;
        if (cost_fill[k] != 0)
        begin
            r.sample_count = 5'(cost_fill[k]);
            r.avg_cost_us = 32'(cost_total[k] / 37'(cost_fill[k]));
        end
        if (frame_fill >= 2)
        begin
            tn = frame_ring[(frame_wr + FW - 1) % FW];
            t0 = frame_ring[(frame_wr + FW - frame_fill) % FW];
            if (tn <= t0)
                r.frame_rate_q8 = 32'hFFFF_FFFF;
            else
            begin
                q = (64'(frame_fill) * frsc_pkg::US_PER_S_Q8) / 64'(tn - t0);
                r.frame_rate_q8 = (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
            end
        end
        r.frame_count = 9'(frame_fill);
        return r;
    endfunction

    // driver; the prediction is made at acceptance so config changes land in order
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!s_axis_tvalid || s_axis_tready_q)
            begin
                if (pending_events.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    s_axis_tdata <= 56'(pending_events.pop_front());
                    s_axis_tvalid <= 1'b1;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // acceptance seen at the rising edge
    always @(posedge clk)
    begin
        s_axis_tready_q <= rst_n && s_axis_tvalid && s_axis_tready;
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            expected_reports.push_back(predict_report(event_t'(s_axis_tdata[53:0])));
        end
    end

    // monitor
    always @(posedge clk)
    begin
        report_t got, want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata[77:0];
            if (expected_reports.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected report %h", $time, got);
            end
            else
            begin
                want = expected_reports.pop_front();
                if (got.avg_cost_us !== want.avg_cost_us)
                begin
                    errors++;
                    $display("%0t: avg_cost_us exp %0d got %0d", $time,
                             want.avg_cost_us, got.avg_cost_us);
                end
                if (got.sample_count !== want.sample_count)
                begin
                    errors++;
                    $display("%0t: sample_count exp %0d got %0d", $time,
                             want.sample_count, got.sample_count);
                end
                if (got.frame_rate_q8 !== want.frame_rate_q8)
                begin
                    errors++;
                    $display("%0t: frame_rate_q8 exp %0d got %0d", $time,
                             want.frame_rate_q8, got.frame_rate_q8);
                end
                if (got.frame_count !== want.frame_count)
                begin
                    errors++;
                    $display("%0t: frame_count exp %0d got %0d", $time,
                             want.frame_count, got.frame_count);
                end
            end
        end
    end

    task automatic queue_event(input frsc_pkg::op_t op, input logic [3:0] k,
                               input logic [47:0] t);
        event_t ev;
        ev.op = op;
        ev.kind = k;
        ev.time_us = t;
        pending_events.push_back(ev);
    endtask

    task automatic wait_drained();
        while (pending_events.size() != 0 || s_axis_tvalid || expected_reports.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    task automatic write_frame_kind(input logic [3:0] v);
        @(negedge clk);
        cfg_data <= {4'd0, v};
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        frame_kind = v;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // random mix of ops, with large steps, repeats and backwards time
    task automatic queue_random(input int n);
        int i;
        logic [47:0] step;
        for (i = 0; i < n; i++)
        begin
            case ($urandom_range(9))
                0: step = 48'({$urandom(), $urandom()});
                1: step = 48'd0;
                2: step = 48'h1_0000_0000 + 48'($urandom_range(3));
                default: step = 48'($urandom_range(20000));
            endcase
            if ($urandom_range(19) == 0)
                clock_us = clock_us - 48'($urandom_range(500));
            else
                clock_us = clock_us + step;
            case ($urandom_range(9))
                0: queue_event(frsc_pkg::OP_MARK, 4'($urandom), clock_us);
                1, 2, 3, 4: queue_event(frsc_pkg::OP_DONE, 4'($urandom), clock_us);
                5, 6, 7: queue_event(frsc_pkg::OP_FRAME, 4'($urandom), clock_us);
                default: queue_event(frsc_pkg::OP_QUERY, 4'($urandom), clock_us);
            endcase
        end
    endtask

    initial
    begin
        int i;
        frame_wr = 0;
        frame_fill = 0;
        mark_time = '0;
        frame_kind = '0;
        for (i = 0; i < NK; i++)
        begin
            cost_wr[i] = 0;
            cost_fill[i] = 0;
            cost_total[i] = '0;
        end
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: every op, extremes, backwards time, zero span, saturation
        queue_event(frsc_pkg::OP_QUERY, 4'd0, 48'd0);
        queue_event(frsc_pkg::OP_FRAME, 4'd9, 48'd10);
        queue_event(frsc_pkg::OP_FRAME, 4'd9, 48'd10);
        queue_event(frsc_pkg::OP_MARK, 4'd15, 48'd1000);
        queue_event(frsc_pkg::OP_DONE, 4'd15, 48'd3000);
        queue_event(frsc_pkg::OP_DONE, 4'd15, 48'd2000);
        queue_event(frsc_pkg::OP_DONE, 4'd3, 48'hFFFF_FFFF_FFFF);
        queue_event(frsc_pkg::OP_FRAME, 4'd0, 48'hFFFF_FFFF_FFFF);
        queue_event(frsc_pkg::OP_QUERY, 4'd3, 48'hAAAA_AAAA_AAAA);
        queue_event(frsc_pkg::OP_MARK, 4'd0, 48'h5555_5555_5555);
        queue_event(frsc_pkg::OP_FRAME, 4'd5, 48'h5555_5555_5556);
        queue_event(frsc_pkg::OP_QUERY, 4'd15, 48'd0);
        wait_drained();
        write_frame_kind(4'd15);
        queue_event(frsc_pkg::OP_FRAME, 4'd0, 48'd20);
        queue_event(frsc_pkg::OP_FRAME, 4'd0, 48'd21);
        queue_event(frsc_pkg::OP_QUERY, 4'd15, 48'd21);
        wait_drained();
        write_frame_kind(4'd0);

        send_idle_pct = 21;
        recv_idle_pct = 70;
        queue_random(130);
        wait_drained();
        write_frame_kind(4'($urandom));
        send_idle_pct = 70;
        recv_idle_pct = 21;
        queue_random(130);
        wait_drained();
        write_frame_kind(4'd15);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_random(150);
        wait_drained();

        if (errors == 0)
            $display("frame_rate_and_stage_cost_monitor_tb: clean");
        else
            $display("frame_rate_and_stage_cost_monitor_tb: errors");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("frame_rate_and_stage_cost_monitor_tb: errors");
        $finish;
    end
endmodule
`default_nettype wire
